// ===== hw/rtl/vlms_pkg.sv =====
package vlms_pkg;

    localparam int IN_W  = 16;
    localparam int OUT_W = 48;
    localparam int NUM_W = 48;
    localparam int CFG_W = 32;

    typedef enum logic [0:0] {
        CFG_STIFF_SCALE = 1'b0,
        CFG_BUOY_SCALE  = 1'b1
    } t_cfg_idx;

    localparam logic [63:0] SHEAR_MAX   = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] LAMBDA_POS  = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] LAMBDA_NEG  = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic [IN_W-1:0] shear_vel;
        logic [IN_W-1:0] press_vel;
        logic [IN_W-1:0] density;
        logic            last_in;
    } t_in_item;

    typedef struct packed {
        logic        [OUT_W-1:0] shear_mod;
        logic signed [OUT_W-1:0] lambda_mod;
        logic        [OUT_W-1:0] buoyancy;
        logic                    saturated;
        logic                    div_error;
        logic                    last_out;
    } t_out_item;

endpackage

// ===== hw/rtl/vlms_div.sv =====
module vlms_div import vlms_pkg::*; #(
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    // one quotient bit per stage, restoring
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];

    genvar g;
    generate
        for (g = 0; g < NUM_W; g++) begin : g_stage
            logic [DEN_W-1:0] p_rem;
            logic [NUM_W-1:0] p_num;
            logic [NUM_W-1:0] p_quo;
            logic [DEN_W-1:0] p_den;
            logic [DEN_W:0]   trial;
            logic             take;
            if (g == 0) begin : g_first
                assign p_rem = '0;
                assign p_num = i_num;
                assign p_quo = '0;
                assign p_den = i_den;
            end else begin : g_next
                assign p_rem = r_rem[g-1];
                assign p_num = r_num[g-1];
                assign p_quo = r_quo[g-1];
                assign p_den = r_den[g-1];
            end
            assign trial = {p_rem, p_num[NUM_W-1]};
            assign take  = (trial >= {1'b0, p_den});
            always_ff @(posedge i_clk) begin
                r_rem[g] <= take ? DEN_W'(trial - {1'b0, p_den}) : trial[DEN_W-1:0];
                r_num[g] <= {p_num[NUM_W-2:0], 1'b0};
                r_quo[g] <= {p_quo[NUM_W-2:0], take};
                r_den[g] <= p_den;
            end
        end
    endgenerate

    assign o_quo = r_quo[NUM_W-1];

endmodule

// ===== hw/rtl/velocity_to_lame_moduli_scaler_unit.sv =====
// path from the accepting edge to the edge that takes the result:
// input register, 48 divider stages, output register
// throughput: one transaction per cycle, o_busy stays low; the receiver cannot stall
// the pipeline depth is set by the buoyancy divider, one quotient bit per stage
// reset (synchronous, active low) clears valid bits and loads both scales with 1.0
module velocity_to_lame_moduli_scaler_unit import vlms_pkg::*; #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  t_in_item         i_item,
    output logic             o_done,
    output t_out_item        o_result,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // velocities and density are used in their low VW bits
    localparam int VW   = (VALUE_WIDTH < IN_W) ? VALUE_WIDTH : IN_W;
    localparam int SQ_W = 2 * VW;
    localparam int MG_W = 2 * VW + 1;
    localparam int PW   = 3 * VW + 1;
    localparam int PP_W = (PW > 32) ? PW : 33;
    localparam int HI_W = PP_W - 32;
    localparam int FW   = PP_W + 32;
    localparam int MOD_LAT = 6;
    localparam int DLY  = NUM_W - MOD_LAT;

    typedef struct packed {
        logic [OUT_W-1:0] shear;
        logic [OUT_W-1:0] lambda;
        logic             sat;
        logic             dz;
        logic             last;
    } t_mod;

    // configuration registers
    logic [CFG_W-1:0] r_stiff, r_buoy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= CFG_W'(65536);
            r_buoy  <= CFG_W'(65536);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STIFF_SCALE: r_stiff <= i_cfg_data;
                CFG_BUOY_SCALE:  r_buoy  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // no back pressure anywhere: a transaction is taken on any start
    assign o_busy = 1'b0;

    // stage 0: input capture
    logic          r0_v, r0_last;
    logic [VW-1:0] r0_vs, r0_vp, r0_rho;

    // stage 1: squares
    logic            r1_v, r1_last;
    logic [SQ_W-1:0] r1_vs2, r1_vp2;
    logic [VW-1:0]   r1_rho;

    // stage 2: lambda base as sign and magnitude
    logic            r2_v, r2_last, r2_neg;
    logic [SQ_W-1:0] r2_vs2;
    logic [MG_W-1:0] r2_mag;
    logic [VW-1:0]   r2_rho;

    // stage 3: products with density
    logic            r3_v, r3_last, r3_neg, r3_dz;
    logic [PP_W-1:0] r3_mu_p, r3_lam_p;

    // stage 4: partial products with stiff_scale
    logic            r4_v, r4_last, r4_neg, r4_dz;
    logic [63:0]     r4_mu_lo, r4_lam_lo;
    logic [HI_W+31:0] r4_mu_hi, r4_lam_hi;

    // stage 5: recombine, shift by 32, ceiling for negative lambda
    logic            r5_v, r5_last, r5_neg, r5_dz;
    logic [PP_W-1:0] r5_mu_q, r5_lam_q;

    // stage 6: clip to 48 bits
    logic            r6_v;
    t_mod            r6_mod;

    logic [SQ_W:0]   two_vs2;
    logic [SQ_W:0]   vp2_ext;
    logic            lam_neg;
    logic [FW-1:0]   mu_full, lam_full, lam_round;
    logic [63:0]     mu_q64, lam_q64;
    t_mod            n6_mod;

    assign two_vs2 = {r1_vs2, 1'b0};
    assign vp2_ext = {1'b0, r1_vp2};
    assign lam_neg = (vp2_ext < two_vs2);

    assign mu_full   = FW'(r4_mu_lo) + {r4_mu_hi, 32'b0};
    assign lam_round = r4_neg ? FW'(64'h0000_0000_FFFF_FFFF) : '0;
    assign lam_full  = FW'(r4_lam_lo) + {r4_lam_hi, 32'b0} + lam_round;

    assign mu_q64  = 64'(r5_mu_q);
    assign lam_q64 = 64'(r5_lam_q);

    always_comb begin
        n6_mod.dz   = r5_dz;
        n6_mod.last = r5_last;
        n6_mod.sat  = 1'b0;
        if (mu_q64 > SHEAR_MAX) begin
            n6_mod.shear = SHEAR_MAX[OUT_W-1:0];
            n6_mod.sat   = 1'b1;
        end else begin
            n6_mod.shear = mu_q64[OUT_W-1:0];
        end
        if (!r5_neg) begin
            if (lam_q64 > LAMBDA_POS) begin
                n6_mod.lambda = LAMBDA_POS[OUT_W-1:0];
                n6_mod.sat    = 1'b1;
            end else begin
                n6_mod.lambda = lam_q64[OUT_W-1:0];
            end
        end else begin
            if (lam_q64 > LAMBDA_NEG) begin
                n6_mod.lambda = LAMBDA_NEG[OUT_W-1:0];
                n6_mod.sat    = 1'b1;
            end else begin
                n6_mod.lambda = OUT_W'(0) - lam_q64[OUT_W-1:0];
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else begin
            r0_v <= i_start;
            r1_v <= r0_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r0_vs   <= i_item.shear_vel[VW-1:0];
        r0_vp   <= i_item.press_vel[VW-1:0];
        r0_rho  <= i_item.density[VW-1:0];
        r0_last <= i_item.last_in;

        r1_vs2  <= r0_vs * r0_vs;
        r1_vp2  <= r0_vp * r0_vp;
        r1_rho  <= r0_rho;
        r1_last <= r0_last;

        r2_vs2  <= r1_vs2;
        r2_neg  <= lam_neg;
        r2_mag  <= lam_neg ? (two_vs2 - vp2_ext) : (vp2_ext - two_vs2);
        r2_rho  <= r1_rho;
        r2_last <= r1_last;

        r3_mu_p  <= PP_W'(r2_vs2) * PP_W'(r2_rho);
        r3_lam_p <= PP_W'(r2_mag) * PP_W'(r2_rho);
        r3_neg   <= r2_neg;
        r3_dz    <= (r2_rho == '0);
        r3_last  <= r2_last;

        r4_mu_lo  <= 64'(r3_mu_p[31:0]) * 64'(r_stiff);
        r4_lam_lo <= 64'(r3_lam_p[31:0]) * 64'(r_stiff);
        r4_mu_hi  <= (HI_W+32)'(r3_mu_p[PP_W-1:32]) * (HI_W+32)'(r_stiff);
        r4_lam_hi <= (HI_W+32)'(r3_lam_p[PP_W-1:32]) * (HI_W+32)'(r_stiff);
        r4_neg    <= r3_neg;
        r4_dz     <= r3_dz;
        r4_last   <= r3_last;

        r5_mu_q  <= mu_full[FW-1:32];
        r5_lam_q <= lam_full[FW-1:32];
        r5_neg   <= r4_neg;
        r5_dz    <= r4_dz;
        r5_last  <= r4_last;

        r6_mod <= n6_mod;
    end

    // buoyancy: (buoy_scale << 16) / rho, started from stage 0
    logic [NUM_W-1:0] div_quo;

    vlms_div #(
        .DEN_W (VW)
    ) u_div (
        .i_clk (i_clk),
        .i_num ({r_buoy, 16'b0}),
        .i_den (r0_rho),
        .o_quo (div_quo)
    );

    // delay moduli results to line up with the divider output
    logic r_dl_v   [DLY];
    t_mod r_dl_mod [DLY];

    genvar g;
    generate
        for (g = 0; g < DLY; g++) begin : g_dly
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dl_v[g] <= 1'b0;
                end else begin
                    r_dl_v[g] <= (g == 0) ? r6_v : r_dl_v[(g == 0) ? 0 : g-1];
                end
                r_dl_mod[g] <= (g == 0) ? r6_mod : r_dl_mod[(g == 0) ? 0 : g-1];
            end
        end
    endgenerate

    // output register
    t_mod      al_mod;
    t_out_item n_result;

    assign al_mod = r_dl_mod[DLY-1];

    always_comb begin
        n_result.shear_mod  = al_mod.shear;
        n_result.lambda_mod = al_mod.lambda;
        // zero density gives zero buoyancy and the error flag
        n_result.buoyancy   = al_mod.dz ? '0 : div_quo;
        n_result.saturated  = al_mod.sat;
        n_result.div_error  = al_mod.dz;
        n_result.last_out   = al_mod.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_dl_v[DLY-1];
        end
        o_result <= n_result;
    end

endmodule

// ===== test/velocity_to_lame_moduli_scaler_unit_tb.sv =====
`timescale 1ns / 1ps

import vlms_pkg::*;

// expected moduli store: computes scaled moduli and buoyancy for each accepted
// grid point and compares them against results in arrival order
class lame_moduli_scoreboard;
    logic [31:0] stiff_scale;
    logic [31:0] buoy_scale;
    t_out_item   expected_q[$];
    int          error_count;

    function new();
        stiff_scale = 32'd65536;
        buoy_scale  = 32'd65536;
        error_count = 0;
    endfunction

    function void write_reg(t_cfg_idx idx, logic [31:0] data);
        if (idx == CFG_STIFF_SCALE) begin
            stiff_scale = data;
        end else begin
            buoy_scale = data;
        end
    endfunction

    // predicts the moduli of one grid point
    function void note_point(t_in_item item);
        t_out_item    res;
        logic [95:0]  vs2;
        logic [95:0]  vp2;
        logic [95:0]  mag;
        logic [95:0]  prod;
        logic [95:0]  quot;
        logic [63:0]  buoy_wide;
        logic         sat;
        vs2  = 96'(item.shear_vel) * 96'(item.shear_vel);
        vp2  = 96'(item.press_vel) * 96'(item.press_vel);
        sat  = 1'b0;
        // shear modulus, floor of the scaled product
        prod = vs2 * 96'(item.density) * 96'(stiff_scale);
        quot = prod >> 32;
        if (quot > 96'(SHEAR_MAX)) begin
            quot = 96'(SHEAR_MAX);
            sat  = 1'b1;
        end
        res.shear_mod = quot[47:0];
        // lambda, floor toward minus infinity when negative
        if (vp2 >= 2 * vs2) begin
            mag  = vp2 - 2 * vs2;
            prod = mag * 96'(item.density) * 96'(stiff_scale);
            quot = prod >> 32;
            if (quot > 96'(LAMBDA_POS)) begin
                quot = 96'(LAMBDA_POS);
                sat  = 1'b1;
            end
            res.lambda_mod = quot[47:0];
        end else begin
            mag  = 2 * vs2 - vp2;
            prod = mag * 96'(item.density) * 96'(stiff_scale);
            quot = (prod + 96'hFFFF_FFFF) >> 32;
            if (quot > 96'(LAMBDA_NEG)) begin
                quot = 96'(LAMBDA_NEG);
                sat  = 1'b1;
            end
            res.lambda_mod = 48'(0) - quot[47:0];
        end
        // buoyancy never clips, zero density flags an error
        if (item.density == '0) begin
            buoy_wide     = '0;
            res.div_error = 1'b1;
        end else begin
            buoy_wide     = {buoy_scale, 16'h0} / 64'(item.density);
            res.div_error = 1'b0;
        end
        res.buoyancy  = buoy_wide[47:0];
        res.saturated = sat;
        res.last_out  = item.last_in;
        expected_q.push_back(res);
    endfunction

    function void check_result(t_out_item got);
        t_out_item exp_res;
        if (expected_q.size() == 0) begin
            $display("%0t: result with no transaction pending, actual %h", $time, got);
            error_count++;
            return;
        end
        exp_res = expected_q.pop_front();
        if (got.shear_mod !== exp_res.shear_mod) begin
            $display("%0t: shear_mod expected %h actual %h", $time,
                     exp_res.shear_mod, got.shear_mod);
            error_count++;
        end
        if (got.lambda_mod !== exp_res.lambda_mod) begin
            $display("%0t: lambda_mod expected %h actual %h", $time,
                     exp_res.lambda_mod, got.lambda_mod);
            error_count++;
        end
        if (got.buoyancy !== exp_res.buoyancy) begin
            $display("%0t: buoyancy expected %h actual %h", $time,
                     exp_res.buoyancy, got.buoyancy);
            error_count++;
        end
        if (got.saturated !== exp_res.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time,
                     exp_res.saturated, got.saturated);
            error_count++;
        end
        if (got.div_error !== exp_res.div_error) begin
            $display("%0t: div_error expected %b actual %b", $time,
                     exp_res.div_error, got.div_error);
            error_count++;
        end
        if (got.last_out !== exp_res.last_out) begin
            $display("%0t: last_out expected %b actual %b", $time,
                     exp_res.last_out, got.last_out);
            error_count++;
        end
    endfunction
endclass

module velocity_to_lame_moduli_scaler_unit_tb;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    t_in_item         i_item;
    logic             o_done;
    t_out_item        o_result;
    logic             i_cfg_we;
    t_cfg_idx         i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;

    lame_moduli_scoreboard moduli_sb;
    bit                    no_idle;

    velocity_to_lame_moduli_scaler_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // result monitor, the receiver never stalls so every strobe is a transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            moduli_sb.check_result(o_result);
        end
    end

    // register write, only issued while the pipeline is empty
    task automatic write_cfg(t_cfg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        moduli_sb.write_reg(idx, data);
    endtask

    // one grid point, with a random idle gap in front of it about a quarter of the time
    task automatic send_point(t_in_item item);
        while (!no_idle && $urandom_range(0, 99) < 26) begin
            @(negedge i_clk);
            i_start = 1'b0;
        end
        @(negedge i_clk);
        i_start = 1'b1;
        i_item  = item;
        do begin
            @(posedge i_clk);
        end while (o_busy);
        moduli_sb.note_point(item);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    // drain the pipeline, then wait out its latency before touching registers
    task automatic drain();
        while (moduli_sb.expected_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_point();
        t_in_item p;
        p.shear_vel = pick_value();
        p.density   = pick_value();
        // keep most points physical (vp above vs), some with lambda negative
        if ($urandom_range(0, 3) == 0) begin
            p.press_vel = pick_value();
        end else begin
            p.press_vel = 16'($urandom_range(int'(p.shear_vel), 65535));
        end
        p.last_in = ($urandom_range(0, 15) == 0);
        return p;
    endfunction

    task automatic random_burst(int count);
        for (int n = 0; n < count; n++) begin
            send_point(random_point());
        end
        end_burst();
    endtask

    function automatic t_in_item mk(logic [15:0] vs, logic [15:0] vp, logic [15:0] rho,
                                    logic last);
        t_in_item p;
        p.shear_vel = vs;
        p.press_vel = vp;
        p.density   = rho;
        p.last_in   = last;
        return p;
    endfunction

    initial begin
        moduli_sb  = new();
        no_idle    = 1'b0;
        i_rst_n    = 1'b0;
        i_start    = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_STIFF_SCALE;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed points at the reset scales
        send_point(mk(16'd0, 16'd0, 16'd0, 1'b0));          // zero density
        send_point(mk(16'd3000, 16'd6000, 16'd0, 1'b1));    // zero density, nonzero speeds
        send_point(mk(16'd3000, 16'd6000, 16'd2500, 1'b0)); // typical rock
        send_point(mk(16'd4000, 16'd5000, 16'd2700, 1'b0)); // negative lambda
        send_point(mk(16'd1, 16'd1, 16'd1, 1'b0));          // tiny negative lambda rounds down
        send_point(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_point(mk(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0));
        send_point(mk(16'h0000, 16'hFFFF, 16'hFFFF, 1'b0));
        send_point(mk(16'd0, 16'd0, 16'd1, 1'b0));
        send_point(mk(16'd0, 16'd0, 16'hFFFF, 1'b0));
        end_burst();
        drain();

        // largest scales drive lambda into saturation at both signs
        write_cfg(CFG_STIFF_SCALE, 32'hFFFF_FFFF);
        write_cfg(CFG_BUOY_SCALE, 32'hFFFF_FFFF);
        send_point(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        send_point(mk(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1)); // lambda clips negative
        send_point(mk(16'h0000, 16'hFFFF, 16'hFFFF, 1'b0)); // lambda clips positive
        send_point(mk(16'h0100, 16'h0200, 16'h0001, 1'b0));
        send_point(mk(16'h0001, 16'h0001, 16'h0001, 1'b0)); // buoyancy at its top
        send_point(mk(16'h1234, 16'h5678, 16'h0000, 1'b0));
        end_burst();
        drain();

        // zero scales
        write_cfg(CFG_STIFF_SCALE, 32'h0);
        write_cfg(CFG_BUOY_SCALE, 32'h0);
        send_point(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        send_point(mk(16'hFFFF, 16'h0000, 16'h0001, 1'b0));
        send_point(mk(16'h0000, 16'h0000, 16'h0000, 1'b0));
        random_burst(40);
        drain();

        // mostly random scales, with a long burst at full rate in the middle
        for (int phase = 0; phase < 4; phase++) begin
            write_cfg(CFG_STIFF_SCALE, (phase == 3) ? 32'hFFFF_FFFF : 32'($urandom));
            write_cfg(CFG_BUOY_SCALE, (phase == 0) ? 32'h0000_0001 : 32'($urandom));
            no_idle = (phase == 1);
            random_burst((phase == 1) ? 200 : 100);
            no_idle = 1'b0;
            drain();
        end

        // back to unity scales
        write_cfg(CFG_STIFF_SCALE, 32'd65536);
        write_cfg(CFG_BUOY_SCALE, 32'd65536);
        random_burst(110);
        drain();

        if (moduli_sb.error_count == 0 && moduli_sb.expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
